@@ src/look_at_view_matrix_unit_macros.svh @@
// Assertion helpers for the look-at view matrix unit.
`ifndef LOOK_AT_VIEW_MATRIX_UNIT_MACROS_SVH
`define LOOK_AT_VIEW_MATRIX_UNIT_MACROS_SVH
`ifndef SYNTH
// Same-cycle implication.
`define LAVM_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lavm: same-cycle check failed");
// Next-cycle implication.
`define LAVM_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lavm: next-cycle check failed");
`else
`define LAVM_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define LAVM_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

@@ src/lavm_pkg.sv @@
package lavm_pkg;

    // Vector entering a normalizer: signed, wide enough for the cross product
    localparam int VEC_W   = 51;
    localparam int MAG_W   = 51;
    localparam int POS_W   = 6;
    // Scaled magnitude: leading one lands on bit TOP_POS
    localparam int M_W     = 31;
    localparam int TOP_POS = 30;
    localparam int SQ_W    = 2 * M_W;
    localparam int SUM_W   = 64;
    // Square root unit
    localparam int ROOT_W   = 32;
    localparam int REM_W    = 36;
    localparam int SQ_STEPS = 2;
    localparam int SQ_ST    = ROOT_W / SQ_STEPS;
    // Divider
    localparam int NUM_W     = 48;
    localparam int QUO_W     = 18;
    localparam int DREM_W    = 32;
    localparam int DIV_STEPS = 2;
    localparam int DIV_ST    = QUO_W / DIV_STEPS;
    // Normalized axis component, Q16.16 in [-1, 1]
    localparam int AX_W   = 18;
    localparam int SIDE_W = 192;

    localparam logic [31:0] ONE_Q16 = 32'h0001_0000;

    // Row codes
    localparam logic [1:0] ROW_X = 2'd0;
    localparam logic [1:0] ROW_Y = 2'd1;
    localparam logic [1:0] ROW_Z = 2'd2;
    localparam logic [1:0] ROW_W = 2'd3;

    typedef struct packed {
        logic [SIDE_W-1:0]        side;
        logic [2:0]               neg;
        logic                     zero;
        logic [2:0][M_W-1:0]      m;
    } lavm_meta_t;

    typedef struct packed {
        logic [REM_W-1:0]  rem;
        logic [ROOT_W-1:0] root;
    } sqrt_st_t;

    typedef struct packed {
        logic [DREM_W-1:0] rem;
        logic [QUO_W-1:0]  quo;
    } div_st_t;

endpackage

@@ src/lavm_norm.sv @@
module lavm_norm (
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic                                      en,
    input  logic                                      in_vld,
    input  logic [2:0][lavm_pkg::VEC_W-1:0]           v,
    input  logic [lavm_pkg::SIDE_W-1:0]               in_side,
    output logic                                      out_vld,
    output logic [2:0][lavm_pkg::AX_W-1:0]            axis,
    output logic                                      zero,
    output logic [lavm_pkg::SIDE_W-1:0]               out_side
);

    // One square root digit: bring down two bits, try root*4+1
    function automatic lavm_pkg::sqrt_st_t sqrt_step(input lavm_pkg::sqrt_st_t s,
                                                     input logic [1:0] pair);
        logic [lavm_pkg::REM_W-1:0] r2;
        logic [lavm_pkg::REM_W-1:0] trial;
        lavm_pkg::sqrt_st_t         o;
        r2    = {s.rem[lavm_pkg::REM_W-3:0], pair};
        trial = {{(lavm_pkg::REM_W-lavm_pkg::ROOT_W-2){1'b0}}, s.root, 2'b01};
        if (r2 >= trial)
        begin
            o.rem  = r2 - trial;
            o.root = {s.root[lavm_pkg::ROOT_W-2:0], 1'b1};
        end
        else
        begin
            o.rem  = r2;
            o.root = {s.root[lavm_pkg::ROOT_W-2:0], 1'b0};
        end
        return o;
    endfunction

    // One restoring division step
    function automatic lavm_pkg::div_st_t div_step(input lavm_pkg::div_st_t s,
                                                   input logic nbit,
                                                   input logic [lavm_pkg::DREM_W-1:0] len);
        logic [lavm_pkg::DREM_W:0] r2;
        logic                      qb;
        lavm_pkg::div_st_t         o;
        r2 = {s.rem, nbit};
        qb = (r2 >= {1'b0, len});
        if (qb)
        begin
            r2 = r2 - {1'b0, len};
        end
        o.rem = r2[lavm_pkg::DREM_W-1:0];
        o.quo = {s.quo[lavm_pkg::QUO_W-2:0], qb};
        return o;
    endfunction

    // Valid bits
    logic                        a_vld_reg, b_vld_reg, c_vld_reg, d_vld_reg, e_vld_reg;
    logic [lavm_pkg::SQ_ST-1:0]  sq_vld_reg;
    logic                        f_vld_reg;
    logic [lavm_pkg::DIV_ST-1:0] dv_vld_reg;
    logic                        g_vld_reg;

    // Stage A: sign and magnitude
    logic [2:0][lavm_pkg::MAG_W-1:0] a_mag_reg, a_mag_next;
    logic [2:0]                      a_neg_reg, a_neg_next;
    logic [lavm_pkg::MAG_W-1:0]      a_or_reg, a_or_next;
    logic [lavm_pkg::SIDE_W-1:0]     a_side_reg;

    // Stage B: leading one
    logic [2:0][lavm_pkg::MAG_W-1:0] b_mag_reg;
    logic [2:0]                      b_neg_reg;
    logic [lavm_pkg::POS_W-1:0]      b_pos_reg, b_pos_next;
    logic                            b_zero_reg, b_zero_next;
    logic [lavm_pkg::SIDE_W-1:0]     b_side_reg;

    // Stage C: scaled magnitudes
    lavm_pkg::lavm_meta_t            c_meta_reg, c_meta_next;

    // Stage D: squares
    logic [2:0][lavm_pkg::SQ_W-1:0]  d_sq_reg, d_sq_next;
    lavm_pkg::lavm_meta_t            d_meta_reg;

    // Stage E: sum of squares
    logic [lavm_pkg::SUM_W-1:0]      e_sum_reg, e_sum_next;
    lavm_pkg::lavm_meta_t            e_meta_reg;

    // Square root stages
    lavm_pkg::sqrt_st_t              sq_st_reg   [lavm_pkg::SQ_ST];
    lavm_pkg::sqrt_st_t              sq_st_next  [lavm_pkg::SQ_ST];
    logic [lavm_pkg::SUM_W-1:0]      sq_n_reg    [lavm_pkg::SQ_ST];
    logic [lavm_pkg::SUM_W-1:0]      sq_n_next   [lavm_pkg::SQ_ST];
    lavm_pkg::lavm_meta_t            sq_meta_reg [lavm_pkg::SQ_ST];

    // Stage F: numerators
    lavm_pkg::div_st_t               f_st_reg  [3];
    lavm_pkg::div_st_t               f_st_next [3];
    logic [lavm_pkg::QUO_W-1:0]      f_low_reg  [3];
    logic [lavm_pkg::QUO_W-1:0]      f_low_next [3];
    logic [lavm_pkg::DREM_W-1:0]     f_len_reg;
    lavm_pkg::lavm_meta_t            f_meta_reg;

    // Divider stages
    lavm_pkg::div_st_t               dv_st_reg   [lavm_pkg::DIV_ST][3];
    lavm_pkg::div_st_t               dv_st_next  [lavm_pkg::DIV_ST][3];
    logic [lavm_pkg::QUO_W-1:0]      dv_low_reg  [lavm_pkg::DIV_ST][3];
    logic [lavm_pkg::QUO_W-1:0]      dv_low_next [lavm_pkg::DIV_ST][3];
    logic [lavm_pkg::DREM_W-1:0]     dv_len_reg  [lavm_pkg::DIV_ST];
    lavm_pkg::lavm_meta_t            dv_meta_reg [lavm_pkg::DIV_ST];

    // Stage G: signed result
    logic [2:0][lavm_pkg::AX_W-1:0]  g_axis_reg, g_axis_next;
    logic                            g_zero_reg;
    logic [lavm_pkg::SIDE_W-1:0]     g_side_reg;

    // Take magnitudes and their common OR
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            a_neg_next[i] = v[i][lavm_pkg::VEC_W-1];
            a_mag_next[i] = a_neg_next[i] ? (~v[i] + 1'b1) : v[i];
        end
        a_or_next = a_mag_next[0] | a_mag_next[1] | a_mag_next[2];
    end

    // Find the leading one of the largest magnitude
    always_comb
    begin
        b_pos_next = '0;
        for (int j = 0; j < lavm_pkg::MAG_W; j++)
        begin
            if (a_or_reg[j])
            begin
                b_pos_next = lavm_pkg::POS_W'(j);
            end
        end
        b_zero_next = (a_or_reg == '0);
    end

    // Scale all magnitudes so the largest sits in [2^30, 2^31)
    always_comb
    begin
        logic [lavm_pkg::MAG_W-1:0] sh;
        c_meta_next.side = b_side_reg;
        c_meta_next.neg  = b_neg_reg;
        c_meta_next.zero = b_zero_reg;
        for (int i = 0; i < 3; i++)
        begin
            if (b_pos_reg >= lavm_pkg::POS_W'(lavm_pkg::TOP_POS))
            begin
                sh = b_mag_reg[i] >> (b_pos_reg - lavm_pkg::POS_W'(lavm_pkg::TOP_POS));
            end
            else
            begin
                sh = b_mag_reg[i] << (lavm_pkg::POS_W'(lavm_pkg::TOP_POS) - b_pos_reg);
            end
            c_meta_next.m[i] = sh[lavm_pkg::M_W-1:0];
        end
    end

    // Square and sum
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            d_sq_next[i] = lavm_pkg::SQ_W'(c_meta_reg.m[i]) * lavm_pkg::SQ_W'(c_meta_reg.m[i]);
        end
        e_sum_next = lavm_pkg::SUM_W'(d_sq_reg[0]) + lavm_pkg::SUM_W'(d_sq_reg[1])
                   + lavm_pkg::SUM_W'(d_sq_reg[2]);
    end

    // Advance the square root, two digits a stage
    always_comb
    begin
        lavm_pkg::sqrt_st_t         st;
        logic [lavm_pkg::SUM_W-1:0] n;
        for (int k = 0; k < lavm_pkg::SQ_ST; k++)
        begin
            if (k == 0)
            begin
                st = '0;
                n  = e_sum_reg;
            end
            else
            begin
                st = sq_st_reg[k-1];
                n  = sq_n_reg[k-1];
            end
            for (int j = 0; j < lavm_pkg::SQ_STEPS; j++)
            begin
                st = sqrt_step(st, n[lavm_pkg::SUM_W-1 -: 2]);
                n  = n << 2;
            end
            sq_st_next[k] = st;
            sq_n_next[k]  = n;
        end
    end

    // Build numerators m * 65536 + len / 2
    always_comb
    begin
        logic [lavm_pkg::DREM_W-1:0] len;
        logic [lavm_pkg::NUM_W-1:0]  num;
        len = sq_st_reg[lavm_pkg::SQ_ST-1].root;
        for (int i = 0; i < 3; i++)
        begin
            num = {1'b0, sq_meta_reg[lavm_pkg::SQ_ST-1].m[i], 16'h0000}
                + {17'h0_0000, len[lavm_pkg::DREM_W-1:1]};
            f_st_next[i].rem = {2'b00, num[lavm_pkg::NUM_W-1:lavm_pkg::QUO_W]};
            f_st_next[i].quo = '0;
            f_low_next[i]    = num[lavm_pkg::QUO_W-1:0];
        end
    end

    // Advance the three dividers, two quotient bits a stage
    always_comb
    begin
        lavm_pkg::div_st_t           st;
        logic [lavm_pkg::QUO_W-1:0]  low;
        logic [lavm_pkg::DREM_W-1:0] ln;
        for (int k = 0; k < lavm_pkg::DIV_ST; k++)
        begin
            for (int i = 0; i < 3; i++)
            begin
                if (k == 0)
                begin
                    st  = f_st_reg[i];
                    low = f_low_reg[i];
                    ln  = f_len_reg;
                end
                else
                begin
                    st  = dv_st_reg[k-1][i];
                    low = dv_low_reg[k-1][i];
                    ln  = dv_len_reg[k-1];
                end
                for (int j = 0; j < lavm_pkg::DIV_STEPS; j++)
                begin
                    st  = div_step(st, low[lavm_pkg::QUO_W-1], ln);
                    low = low << 1;
                end
                dv_st_next[k][i]  = st;
                dv_low_next[k][i] = low;
            end
        end
    end

    // Apply signs; a zero vector gives a zero axis
    always_comb
    begin
        logic [lavm_pkg::QUO_W-1:0] q;
        for (int i = 0; i < 3; i++)
        begin
            q = dv_st_reg[lavm_pkg::DIV_ST-1][i].quo;
            if (dv_meta_reg[lavm_pkg::DIV_ST-1].zero)
            begin
                g_axis_next[i] = '0;
            end
            else if (dv_meta_reg[lavm_pkg::DIV_ST-1].neg[i])
            begin
                g_axis_next[i] = ~q + 1'b1;
            end
            else
            begin
                g_axis_next[i] = q;
            end
        end
    end

    // Move valid bits on each advance
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_vld_reg  <= 1'b0;
            b_vld_reg  <= 1'b0;
            c_vld_reg  <= 1'b0;
            d_vld_reg  <= 1'b0;
            e_vld_reg  <= 1'b0;
            sq_vld_reg <= '0;
            f_vld_reg  <= 1'b0;
            dv_vld_reg <= '0;
            g_vld_reg  <= 1'b0;
        end
        else if (en)
        begin
            a_vld_reg  <= in_vld;
            b_vld_reg  <= a_vld_reg;
            c_vld_reg  <= b_vld_reg;
            d_vld_reg  <= c_vld_reg;
            e_vld_reg  <= d_vld_reg;
            sq_vld_reg <= {sq_vld_reg[lavm_pkg::SQ_ST-2:0], e_vld_reg};
            f_vld_reg  <= sq_vld_reg[lavm_pkg::SQ_ST-1];
            dv_vld_reg <= {dv_vld_reg[lavm_pkg::DIV_ST-2:0], f_vld_reg};
            g_vld_reg  <= dv_vld_reg[lavm_pkg::DIV_ST-1];
        end
    end

    // Move datapath registers on each advance
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_mag_reg  <= a_mag_next;
            a_neg_reg  <= a_neg_next;
            a_or_reg   <= a_or_next;
            a_side_reg <= in_side;

            b_mag_reg  <= a_mag_reg;
            b_neg_reg  <= a_neg_reg;
            b_pos_reg  <= b_pos_next;
            b_zero_reg <= b_zero_next;
            b_side_reg <= a_side_reg;

            c_meta_reg <= c_meta_next;

            d_sq_reg   <= d_sq_next;
            d_meta_reg <= c_meta_reg;

            e_sum_reg  <= e_sum_next;
            e_meta_reg <= d_meta_reg;

            for (int k = 0; k < lavm_pkg::SQ_ST; k++)
            begin
                sq_st_reg[k] <= sq_st_next[k];
                sq_n_reg[k]  <= sq_n_next[k];
                if (k == 0)
                begin
                    sq_meta_reg[k] <= e_meta_reg;
                end
                else
                begin
                    sq_meta_reg[k] <= sq_meta_reg[k-1];
                end
            end

            for (int i = 0; i < 3; i++)
            begin
                f_st_reg[i]  <= f_st_next[i];
                f_low_reg[i] <= f_low_next[i];
            end
            f_len_reg  <= sq_st_reg[lavm_pkg::SQ_ST-1].root;
            f_meta_reg <= sq_meta_reg[lavm_pkg::SQ_ST-1];

            for (int k = 0; k < lavm_pkg::DIV_ST; k++)
            begin
                for (int i = 0; i < 3; i++)
                begin
                    dv_st_reg[k][i]  <= dv_st_next[k][i];
                    dv_low_reg[k][i] <= dv_low_next[k][i];
                end
                if (k == 0)
                begin
                    dv_len_reg[k]  <= f_len_reg;
                    dv_meta_reg[k] <= f_meta_reg;
                end
                else
                begin
                    dv_len_reg[k]  <= dv_len_reg[k-1];
                    dv_meta_reg[k] <= dv_meta_reg[k-1];
                end
            end

            g_axis_reg <= g_axis_next;
            g_zero_reg <= dv_meta_reg[lavm_pkg::DIV_ST-1].zero;
            g_side_reg <= dv_meta_reg[lavm_pkg::DIV_ST-1].side;
        end
    end

    assign out_vld  = g_vld_reg;
    assign axis     = g_axis_reg;
    assign zero     = g_zero_reg;
    assign out_side = g_side_reg;

endmodule

@@ src/look_at_view_matrix_unit.sv @@
// Output: each matrix is presented as row 0 first; rows 1..3 follow
// one per cycle while out_ready is high.
// Flow: each matrix puts four rows on the single output channel; inputs are taken
// only once none remain. The 72-stage pipeline shares one stall and holds nothing back.
// Reset: rst_n clears all valid bits and the row counter at once; datapath is not reset.
`include "look_at_view_matrix_unit_macros.svh"

module look_at_view_matrix_unit (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [31:0] eye_x,
    input  logic signed [31:0] eye_y,
    input  logic signed [31:0] eye_z,
    input  logic signed [31:0] target_x,
    input  logic signed [31:0] target_y,
    input  logic signed [31:0] target_z,
    input  logic signed [31:0] up_x,
    input  logic signed [31:0] up_y,
    input  logic signed [31:0] up_z,
    output logic               out_valid,
    input  logic               out_ready,
    output logic        [1:0]  row_index,
    output logic signed [31:0] elem0,
    output logic signed [31:0] elem1,
    output logic signed [31:0] elem2,
    output logic signed [31:0] elem3,
    output logic               last_row,
    output logic               degenerate
);

    // Q24.32 to Q24.16 with round half up (floor after adding one half)
    function automatic logic signed [39:0] round16(input logic signed [55:0] v);
        logic signed [55:0] t;
        t = v + 56'sd32768;
        return t[55:16];
    endfunction

    function automatic logic [31:0] sat32(input logic signed [40:0] v);
        logic [31:0] r;
        if (v > 41'sd2147483647)
        begin
            r = 32'h7fff_ffff;
        end
        else if (v < -41'sd2147483648)
        begin
            r = 32'h8000_0000;
        end
        else
        begin
            r = v[31:0];
        end
        return r;
    endfunction

    logic adv;

    // T1: eye - target
    logic                                 t1_vld_reg;
    logic [2:0][lavm_pkg::VEC_W-1:0]      t1_d_reg;
    logic [lavm_pkg::SIDE_W-1:0]          t1_side_reg;

    // First normalizer: z axis
    logic                                 n1_vld;
    logic [2:0][lavm_pkg::AX_W-1:0]       n1_axis;
    logic                                 n1_zero;
    logic [lavm_pkg::SIDE_W-1:0]          n1_side;

    // T2: products of up x z
    logic                                 t2_vld_reg;
    logic signed [49:0]                   t2_p_reg  [6];
    logic signed [49:0]                   t2_p_next [6];
    logic [lavm_pkg::SIDE_W-1:0]          t2_side_reg;

    // T3: cross product up x z
    logic                                 t3_vld_reg;
    logic [2:0][lavm_pkg::VEC_W-1:0]      t3_c_reg, t3_c_next;
    logic [lavm_pkg::SIDE_W-1:0]          t3_side_reg;

    // Second normalizer: x axis
    logic                                 n2_vld;
    logic [2:0][lavm_pkg::AX_W-1:0]       n2_axis;
    logic                                 n2_zero;
    logic [lavm_pkg::SIDE_W-1:0]          n2_side;

    // T4: products of z x x
    logic                                 t4_vld_reg;
    logic signed [35:0]                   t4_p_reg  [6];
    logic signed [35:0]                   t4_p_next [6];
    logic [95:0]                          t4_eye_reg;
    logic [2:0][lavm_pkg::AX_W-1:0]       t4_z_reg, t4_x_reg;
    logic                                 t4_degen_reg;

    // T5: y axis
    logic                                 t5_vld_reg;
    logic [2:0][20:0]                     t5_y_reg, t5_y_next;
    logic [95:0]                          t5_eye_reg;
    logic [2:0][lavm_pkg::AX_W-1:0]       t5_z_reg, t5_x_reg;
    logic                                 t5_degen_reg;

    // T6: eye times each axis; axes in order x, y, z
    logic                                 t6_vld_reg;
    logic signed [52:0]                   t6_p_reg  [3][3];
    logic signed [52:0]                   t6_p_next [3][3];
    logic [2:0][2:0][20:0]                t6_ax_reg, t6_ax_next;
    logic                                 t6_degen_reg;

    // T7: dot products
    logic                                 t7_vld_reg;
    logic [2:0][54:0]                     t7_dot_reg, t7_dot_next;
    logic [2:0][2:0][20:0]                t7_ax_reg;
    logic                                 t7_degen_reg;

    // Output matrix and row counter
    logic                                 mat_vld_reg;
    logic [2:0][2:0][31:0]                mat_ax_reg, mat_ax_next;
    logic [2:0][31:0]                     mat_tr_reg, mat_tr_next;
    logic                                 mat_degen_reg;
    logic [1:0]                           row_reg, row_next;

    // Stall everything while a matrix still has rows to deliver
    assign adv      = !mat_vld_reg || (out_ready && (row_reg == lavm_pkg::ROW_W));
    assign in_ready = adv;

    lavm_norm u_norm_z (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (adv),
        .in_vld   (t1_vld_reg),
        .v        (t1_d_reg),
        .in_side  (t1_side_reg),
        .out_vld  (n1_vld),
        .axis     (n1_axis),
        .zero     (n1_zero),
        .out_side (n1_side)
    );

    // up x z partial products; a zero z gives a zero cross product
    always_comb
    begin
        logic signed [31:0] ux, uy, uz;
        logic signed [17:0] zx, zy, zz;
        ux = n1_side[95:64];
        uy = n1_side[63:32];
        uz = n1_side[31:0];
        zx = n1_zero ? 18'sd0 : n1_axis[0];
        zy = n1_zero ? 18'sd0 : n1_axis[1];
        zz = n1_zero ? 18'sd0 : n1_axis[2];
        t2_p_next[0] = uy * zz;
        t2_p_next[1] = uz * zy;
        t2_p_next[2] = uz * zx;
        t2_p_next[3] = ux * zz;
        t2_p_next[4] = ux * zy;
        t2_p_next[5] = uy * zx;
    end

    // Cross product differences
    always_comb
    begin
        t3_c_next[0] = {t2_p_reg[0][49], t2_p_reg[0]} - {t2_p_reg[1][49], t2_p_reg[1]};
        t3_c_next[1] = {t2_p_reg[2][49], t2_p_reg[2]} - {t2_p_reg[3][49], t2_p_reg[3]};
        t3_c_next[2] = {t2_p_reg[4][49], t2_p_reg[4]} - {t2_p_reg[5][49], t2_p_reg[5]};
    end

    lavm_norm u_norm_x (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (adv),
        .in_vld   (t3_vld_reg),
        .v        (t3_c_reg),
        .in_side  (t3_side_reg),
        .out_vld  (n2_vld),
        .axis     (n2_axis),
        .zero     (n2_zero),
        .out_side (n2_side)
    );

    // z x x partial products
    always_comb
    begin
        logic signed [17:0] zx, zy, zz, xx, xy, xz;
        zx = n2_side[95:78];
        zy = n2_side[77:60];
        zz = n2_side[59:42];
        xx = n2_axis[0];
        xy = n2_axis[1];
        xz = n2_axis[2];
        t4_p_next[0] = zy * xz;
        t4_p_next[1] = zz * xy;
        t4_p_next[2] = zz * xx;
        t4_p_next[3] = zx * xz;
        t4_p_next[4] = zx * xy;
        t4_p_next[5] = zy * xx;
    end

    // Round the y axis to Q16.16
    always_comb
    begin
        logic [36:0]        diff;
        logic signed [39:0] r;
        for (int i = 0; i < 3; i++)
        begin
            diff = {t4_p_reg[2*i][35], t4_p_reg[2*i]}
                 - {t4_p_reg[2*i+1][35], t4_p_reg[2*i+1]};
            r = round16({{19{diff[36]}}, diff});
            t5_y_next[i] = r[20:0];
        end
    end

    // Eye times each axis component
    always_comb
    begin
        logic signed [31:0] e;
        logic signed [20:0] a;
        for (int i = 0; i < 3; i++)
        begin
            t6_ax_next[0][i] = {{3{t5_x_reg[i][17]}}, t5_x_reg[i]};
            t6_ax_next[1][i] = t5_y_reg[i];
            t6_ax_next[2][i] = {{3{t5_z_reg[i][17]}}, t5_z_reg[i]};
        end
        for (int k = 0; k < 3; k++)
        begin
            for (int i = 0; i < 3; i++)
            begin
                e = t5_eye_reg[95-32*i -: 32];
                a = t6_ax_next[k][i];
                t6_p_next[k][i] = e * a;
            end
        end
    end

    // Sum the dot products
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            t7_dot_next[k] = {{2{t6_p_reg[k][0][52]}}, t6_p_reg[k][0]}
                           + {{2{t6_p_reg[k][1][52]}}, t6_p_reg[k][1]}
                           + {{2{t6_p_reg[k][2][52]}}, t6_p_reg[k][2]};
        end
    end

    // Translation terms and axis entries; drop everything to zero on a degenerate view
    always_comb
    begin
        logic signed [39:0] r;
        logic signed [40:0] nr;
        for (int k = 0; k < 3; k++)
        begin
            r  = round16({t7_dot_reg[k][54], t7_dot_reg[k]});
            nr = -{r[39], r};
            mat_tr_next[k] = t7_degen_reg ? 32'h0 : sat32(nr);
            for (int i = 0; i < 3; i++)
            begin
                mat_ax_next[k][i] = t7_degen_reg ? 32'h0
                                  : {{11{t7_ax_reg[k][i][20]}}, t7_ax_reg[k][i]};
            end
        end
    end

    // Step the row counter on each output transaction
    always_comb
    begin
        row_next = row_reg;
        if (mat_vld_reg && out_ready)
        begin
            row_next = row_reg + 2'd1;
        end
    end

    // Valid bits and row counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            t1_vld_reg  <= 1'b0;
            t2_vld_reg  <= 1'b0;
            t3_vld_reg  <= 1'b0;
            t4_vld_reg  <= 1'b0;
            t5_vld_reg  <= 1'b0;
            t6_vld_reg  <= 1'b0;
            t7_vld_reg  <= 1'b0;
            mat_vld_reg <= 1'b0;
            row_reg     <= lavm_pkg::ROW_X;
        end
        else
        begin
            row_reg <= row_next;
            if (adv)
            begin
                t1_vld_reg  <= in_valid;
                t2_vld_reg  <= n1_vld;
                t3_vld_reg  <= t2_vld_reg;
                t4_vld_reg  <= n2_vld;
                t5_vld_reg  <= t4_vld_reg;
                t6_vld_reg  <= t5_vld_reg;
                t7_vld_reg  <= t6_vld_reg;
                mat_vld_reg <= t7_vld_reg;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            t1_d_reg[0] <= {{19{eye_x[31]}}, eye_x} - {{19{target_x[31]}}, target_x};
            t1_d_reg[1] <= {{19{eye_y[31]}}, eye_y} - {{19{target_y[31]}}, target_y};
            t1_d_reg[2] <= {{19{eye_z[31]}}, eye_z} - {{19{target_z[31]}}, target_z};
            t1_side_reg <= {eye_x, eye_y, eye_z, up_x, up_y, up_z};

            t2_p_reg    <= t2_p_next;
            t2_side_reg <= {n1_side[191:96],
                            (n1_zero ? 54'h0 : {n1_axis[0], n1_axis[1], n1_axis[2]}),
                            42'h0};

            t3_c_reg    <= t3_c_next;
            t3_side_reg <= t2_side_reg;

            t4_p_reg     <= t4_p_next;
            t4_eye_reg   <= n2_side[191:96];
            t4_z_reg     <= {n2_side[59:42], n2_side[77:60], n2_side[95:78]};
            t4_x_reg     <= n2_axis;
            t4_degen_reg <= n2_zero;

            t5_y_reg     <= t5_y_next;
            t5_eye_reg   <= t4_eye_reg;
            t5_z_reg     <= t4_z_reg;
            t5_x_reg     <= t4_x_reg;
            t5_degen_reg <= t4_degen_reg;

            t6_p_reg     <= t6_p_next;
            t6_ax_reg    <= t6_ax_next;
            t6_degen_reg <= t5_degen_reg;

            t7_dot_reg   <= t7_dot_next;
            t7_ax_reg    <= t6_ax_reg;
            t7_degen_reg <= t6_degen_reg;

            mat_ax_reg    <= mat_ax_next;
            mat_tr_reg    <= mat_tr_next;
            mat_degen_reg <= t7_degen_reg;
        end
    end

    // Select the row on the output
    always_comb
    begin
        case (row_reg)
            lavm_pkg::ROW_X:
            begin
                elem0 = mat_ax_reg[0][0];
                elem1 = mat_ax_reg[0][1];
                elem2 = mat_ax_reg[0][2];
                elem3 = mat_tr_reg[0];
            end
            lavm_pkg::ROW_Y:
            begin
                elem0 = mat_ax_reg[1][0];
                elem1 = mat_ax_reg[1][1];
                elem2 = mat_ax_reg[1][2];
                elem3 = mat_tr_reg[1];
            end
            lavm_pkg::ROW_Z:
            begin
                elem0 = mat_ax_reg[2][0];
                elem1 = mat_ax_reg[2][1];
                elem2 = mat_ax_reg[2][2];
                elem3 = mat_tr_reg[2];
            end
            default:
            begin
                elem0 = '0;
                elem1 = '0;
                elem2 = '0;
                elem3 = lavm_pkg::ONE_Q16;
            end
        endcase
    end

    assign out_valid  = mat_vld_reg;
    assign row_index  = row_reg;
    assign last_row   = (row_reg == lavm_pkg::ROW_W);
    assign degenerate = mat_degen_reg;

    // Checks
    `LAVM_ASSERT_IMP(a_empty_takes, clk, rst_n, !out_valid, in_ready)
    `LAVM_ASSERT_IMP(a_last_frees, clk, rst_n, out_valid && out_ready && last_row, in_ready)
    `LAVM_ASSERT_NXT(a_rows_held, clk, rst_n, out_valid && out_ready && !last_row, out_valid)
    `LAVM_ASSERT_IMP(a_degen_zero, clk, rst_n, out_valid && degenerate && !last_row, elem0 == '0 && elem1 == '0 && elem2 == '0 && elem3 == '0)

endmodule
